[design/tra_pkg.sv]
// Shared types, codes and helpers for the threshold rule alarm table.
// Used by tra_cell, tra_ctrl, the top level and the checker.
// No dependencies.
package tra_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int RES_CAP       = 16;
    localparam int KEY_W         = 8;
    localparam int VAL_W         = 48;
    localparam int CNT_W         = 32;
    localparam int IN_TDATA_W    = 120;
    localparam int OUT_TDATA_W   = 216;

    // rule comparisons
    localparam logic [2:0] OP_GT = 3'd0;
    localparam logic [2:0] OP_GE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_FIRE    = 2'd1;
    localparam logic [1:0] KIND_NOMATCH = 2'd2;

    // severity levels
    localparam logic [1:0] LVL_INFO  = 2'd0;
    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_ERROR = 2'd2;

    // request command
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              adv;
        logic              load_en;
        logic [KEY_W-1:0]  smp_key;
        logic [VAL_W-1:0]  smp_value;
        logic [KEY_W-1:0]  ld_key;
        logic [2:0]        ld_op;
        logic [VAL_W-1:0]  ld_threshold;
        logic [1:0]        ld_level;
        logic [7:0]        ld_evt_code;
    } bcast_t;

    // rule data of the cell that holds the token and fires; zero otherwise
    typedef struct packed {
        logic              hit;
        logic [7:0]        evt_code;
        logic [1:0]        level;
        logic [VAL_W-1:0]  threshold;
        logic [CNT_W-1:0]  fire_count;
    } hit_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              load_status;
        logic [3:0]        rule_index;
        logic [7:0]        evt_code;
        logic [1:0]        level;
        logic [KEY_W-1:0]  event_key;
        logic [VAL_W-1:0]  threshold;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  fire_count;
        logic [CNT_W-1:0]  level_count;
        logic [CNT_W-1:0]  event_total;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

endpackage

[design/tra_cell.sv]
// One rule slot of the alarm table: stored rule, fire count, token stage.
// Depends on tra_pkg.
module tra_cell #(
    parameter int MAX_RULES = tra_pkg::MAX_RULES_DEF,
    parameter int INDEX     = 0,
    parameter int CW        = $clog2(MAX_RULES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tra_pkg::bcast_t bc,
    input  logic [CW-1:0]   rule_count,
    input  logic            tok_in,
    output logic            tok_out,
    output tra_pkg::hit_t   hit_out
);
    import tra_pkg::*;

    logic                    active_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [2:0]              op_reg;
    logic [VAL_W-1:0]        thr_reg;
    logic [1:0]              level_reg;
    logic [7:0]              event_reg;
    logic [CNT_W-1:0]        fcnt_reg;
    logic [CNT_W-1:0]        fcnt_next;
    logic                    loaded;
    logic                    sel;
    logic                    lt;
    logic                    eq;
    logic                    cmp;
    logic                    hit;

    assign loaded = rule_count > CW'(INDEX);
    assign sel    = bc.load_en && (rule_count == CW'(INDEX));
    assign lt     = $signed(bc.smp_value) < $signed(thr_reg);
    assign eq     = bc.smp_value == thr_reg;

    always_comb
    begin
        case (op_reg)
            OP_GT:   cmp = !lt && !eq;
            OP_GE:   cmp = !lt;
            OP_LT:   cmp = lt;
            OP_LE:   cmp = lt || eq;
            OP_EQ:   cmp = eq;
            OP_NE:   cmp = !eq;
            default: cmp = 1'b0;
        endcase
    end

    assign hit       = active_reg && loaded && (key_reg == bc.smp_key) && cmp;
    assign fcnt_next = sat_inc(fcnt_reg);
    assign tok_out   = active_reg;

    always_comb
    begin
        hit_out = '0;
        if (hit)
        begin
            hit_out.hit        = 1'b1;
            hit_out.evt_code   = event_reg;
            hit_out.level      = level_reg;
            hit_out.threshold  = thr_reg;
            hit_out.fire_count = fcnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (bc.adv)
            active_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            key_reg   <= bc.ld_key;
            op_reg    <= bc.ld_op;
            thr_reg   <= bc.ld_threshold;
            level_reg <= bc.ld_level;
            event_reg <= bc.ld_evt_code;
            fcnt_reg  <= '0;
        end
        else if (hit && bc.adv)
        begin
            fcnt_reg  <= fcnt_next;
        end
    end

endmodule

[design/tra_ctrl.sv]
// Sequencer of the alarm table: request intake, token walk, event counters,
// one pending result and the output register. Depends on tra_pkg.
module tra_ctrl #(
    parameter int MAX_RULES = tra_pkg::MAX_RULES_DEF,
    parameter int CW        = $clog2(MAX_RULES + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tra_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tra_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    output tra_pkg::bcast_t                    bc,
    output logic [CW-1:0]                      rule_count,
    output logic                               start,
    input  tra_pkg::hit_t                      hit
);
    import tra_pkg::*;

    localparam int PW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int NW = $clog2(RES_CAP + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     rcnt_reg, rcnt_next;
    logic [NW-1:0]     n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]  evt_reg, evt_next;
    logic [CNT_W-1:0]  info_reg, info_next;
    logic [CNT_W-1:0]  warn_reg, warn_next;
    logic [CNT_W-1:0]  err_reg, err_next;

    logic              accept;
    logic              full;
    logic              out_free;
    logic              emit;
    logic              adv;
    logic              at_end;
    logic [CNT_W-1:0]  lc;
    res_t              res_fire;
    res_t              res_none;
    res_t              res_ack;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (rcnt_reg == CW'(MAX_RULES));
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = hit.hit && (n_reg < NW'(RES_CAP));
    assign adv      = (state_reg == ST_WALK) && !(emit && pend_valid_reg && !out_free);
    assign at_end   = (pos_reg == PW'(MAX_RULES - 1));
    assign start    = accept && (s_tuser == CMD_SAMPLE);

    assign rule_count      = rcnt_reg;
    assign bc.adv          = adv || start;
    assign bc.load_en      = accept && (s_tuser == CMD_LOAD) && !full;
    assign bc.smp_key      = key_reg;
    assign bc.smp_value    = value_reg;
    assign bc.ld_key       = s_tdata[7:0];
    assign bc.ld_op        = s_tdata[58:56];
    assign bc.ld_threshold = s_tdata[106:59];
    assign bc.ld_level     = s_tdata[108:107];
    assign bc.ld_evt_code  = s_tdata[116:109];

    // event counters, updated on every firing in slot order
    always_comb
    begin
        evt_next  = evt_reg;
        info_next = info_reg;
        warn_next = warn_reg;
        err_next  = err_reg;
        lc        = '0;
        if (adv && hit.hit)
        begin
            evt_next = sat_inc(evt_reg);
            case (hit.level)
                LVL_INFO:
                begin
                    info_next = sat_inc(info_reg);
                    lc        = info_next;
                end
                LVL_WARN:
                begin
                    warn_next = sat_inc(warn_reg);
                    lc        = warn_next;
                end
                LVL_ERROR:
                begin
                    err_next = sat_inc(err_reg);
                    lc       = err_next;
                end
                default: lc = '0;
            endcase
        end
    end

    always_comb
    begin
        res_fire             = '0;
        res_fire.kind        = KIND_FIRE;
        res_fire.rule_index  = 4'(pos_reg);
        res_fire.evt_code    = hit.evt_code;
        res_fire.level       = hit.level;
        res_fire.event_key   = key_reg;
        res_fire.threshold   = hit.threshold;
        res_fire.value       = value_reg;
        res_fire.fire_count  = hit.fire_count;
        res_fire.level_count = lc;
        res_fire.event_total = evt_next;

        res_none             = '0;
        res_none.kind        = KIND_NOMATCH;
        res_none.event_key   = key_reg;
        res_none.value       = value_reg;

        res_ack              = '0;
        res_ack.kind         = KIND_ACK;
        res_ack.load_status  = full;
        res_ack.rule_index   = full ? 4'd0 : 4'(rcnt_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        rcnt_next       = rcnt_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        key_next        = key_reg;
        value_next      = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        pend_next       = res_ack;
                        pend_valid_next = 1'b1;
                        if (!full)
                            rcnt_next = rcnt_reg + CW'(1);
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        key_next   = s_tdata[7:0];
                        value_next = s_tdata[55:8];
                        pos_next   = '0;
                        n_next     = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (adv)
                begin
                    if (emit)
                    begin
                        // earlier result is known not to be the last one
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = res_fire;
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + NW'(1);
                    end
                    if (at_end)
                    begin
                        if (!emit && !pend_valid_reg)
                        begin
                            pend_next       = res_none;
                            pend_valid_next = 1'b1;
                        end
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            rcnt_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            evt_reg        <= '0;
            info_reg       <= '0;
            warn_reg       <= '0;
            err_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            rcnt_reg       <= rcnt_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            evt_reg        <= evt_next;
            info_reg       <= info_next;
            warn_reg       <= warn_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, out_reg.event_total, out_reg.level_count, out_reg.fire_count,
                       out_reg.value, out_reg.threshold, out_reg.event_key, out_reg.level,
                       out_reg.evt_code, out_reg.rule_index, out_reg.load_status};

endmodule

[design/threshold_rule_alarm_table.sv]
// Top level of the threshold rule alarm table: sequencer plus a chain of
// rule cells. Depends on tra_pkg, tra_cell and tra_ctrl.
//
// Usage:
//   Slave channel (s_*) takes requests. s_tuser = 0 loads a rule into the
//   next free slot, s_tuser = 1 presents a sample. Master channel (m_*)
//   returns results; m_tuser is the result kind and m_tlast marks the final
//   result of a request.
//   A load gives one acknowledge via the pending stage and output register;
//   a full table acknowledges with load_status set and stores nothing.
//   A sample sends a one-hot token down the chain of MAX_RULES cells, one
//   cell per cycle unless the walk is halted; each cell compares the sample
//   with its own rule. Rules that fire report in slot order. A fired result
//   waits in a pending stage until the next firing rule or the end of the
//   walk shows whether it is the last one, so it reaches m_* then; the final
//   result (or a single no-match result) leaves the pending stage after the walk.
//   One request is handled at a time: a sample occupies the block through the
//   token walk and the flush of its last result, a load through its acknowledge.
//   When the receiver stalls, the walk halts at the next firing cell and
//   resumes when the output register frees up; no result is dropped.
//   Reset empties the table and clears all event counters; rule storage is
//   not cleared, only the slot count.
module threshold_rule_alarm_table #(
    parameter int MAX_RULES = tra_pkg::MAX_RULES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] key_id, [55:8] sample_value, [58:56] rule_op,
    // [106:59] rule_threshold, [108:107] rule_level, [116:109] rule_evt_code
    input  logic [tra_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] load_status, [4:1] rule_index, [12:5] evt_code, [14:13] level,
    // [22:15] event_key, [70:23] threshold, [118:71] value,
    // [150:119] fire_count, [182:151] level_count, [214:183] event_total
    output logic [tra_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [1:0] kind
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);
    import tra_pkg::*;

    localparam int CW = $clog2(MAX_RULES + 1);

    bcast_t          bc;
    logic [CW-1:0]   rule_count;
    logic            start;
    logic            tok [MAX_RULES];
    hit_t            hit_arr [MAX_RULES];
    hit_t            hit_bus;

    tra_ctrl #(
        .MAX_RULES (MAX_RULES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .bc         (bc),
        .rule_count (rule_count),
        .start      (start),
        .hit        (hit_bus)
    );

    // token enters cell 0 and moves one cell per advance
    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        tra_cell #(
            .MAX_RULES (MAX_RULES),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bc         (bc),
            .rule_count (rule_count),
            .tok_in     ((i == 0) ? start : tok[(i == 0) ? 0 : i - 1]),
            .tok_out    (tok[i]),
            .hit_out    (hit_arr[i])
        );
    end

    // only the token holder can drive a nonzero hit
    always_comb
    begin
        hit_bus = '0;
        for (int i = 0; i < MAX_RULES; i++)
            hit_bus = hit_t'(hit_bus | hit_arr[i]);
    end

endmodule

[design/tra_checker.sv]
// Port-level checks for threshold_rule_alarm_table, bound to the top level.
// Depends on tra_pkg.
module tra_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tra_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic [1:0]                       m_tuser,
    input  logic                             m_tlast
);
    import tra_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // acknowledges and no-match results are single-result requests
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACK || m_tuser == KIND_NOMATCH) |-> m_tlast)
        else $error("single result without last");

    // a fired event always carries nonzero fire and total counts and a clear load_status
    a_fire_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FIRE |->
            m_tdata[150:119] != 32'd0 && m_tdata[214:183] != 32'd0 && !m_tdata[0])
        else $error("fired event with zero counts");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule

bind threshold_rule_alarm_table tra_checker u_tra_checker (.*);
